// File: src/hbw_pkg.sv
// Package for the archive block header walker: item, config and phase types,
// status codes and register indexes. No dependencies.
`default_nettype none

package hbw_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIG_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET  = 2'd1;

  localparam logic [7:0] SIG_LEN_RST = 8'd8;
  localparam logic [7:0] TARGET_RST  = 8'd3;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned CRC_W   = 32;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_END      = 2'd2,
    ST_BACKSKIP = 2'd3
  } hbw_status_e;

  typedef enum logic [7:0] {
    PH_SIG   = 8'b0000_0001,
    PH_CRC   = 8'b0000_0010,
    PH_HSIZE = 8'b0000_0100,
    PH_TYPE  = 8'b0000_1000,
    PH_FLAGS = 8'b0001_0000,
    PH_EXTRA = 8'b0010_0000,
    PH_DATA  = 8'b0100_0000,
    PH_SKIP  = 8'b1000_0000
  } hbw_phase_e;

  // classified input byte as queued between front and back
  typedef struct packed {
    logic [7:0] value;
    logic [6:0] group;
    logic       cont;
    logic       last;
  } hbw_item_t;

  typedef struct packed {
    logic [7:0] sig_len;
    logic [7:0] target;
  } hbw_cfg_t;

endpackage

`default_nettype wire

// File: src/hbw_in_if.sv
// Input channel of the header walker: one archive byte per transaction.
// Standalone; no package needed.
`default_nettype none

interface hbw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output byte_value, output last, input ready);
  modport sink   (input valid, input byte_value, input last, output ready);
endinterface

`default_nettype wire

// File: src/hbw_out_if.sv
// Output channel of the header walker: one block descriptor per transaction.
// Standalone; offset width follows OFFSET_BITS.
`default_nettype none

interface hbw_out_if #(
  parameter int unsigned OFFSET_BITS = 48
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] block_offset;
  logic [31:0]            header_crc;
  logic [63:0]            header_size;
  logic [63:0]            block_type;
  logic [63:0]            header_flags;
  logic [63:0]            extra_size;
  logic [63:0]            data_size;
  logic [OFFSET_BITS-1:0] data_offset;
  logic                   is_target;
  logic [1:0]             status;
  logic                   end_of_stream;

  modport source (
    output valid, input ready,
    output block_offset, output header_crc, output header_size, output block_type,
    output header_flags, output extra_size, output data_size, output data_offset,
    output is_target, output status, output end_of_stream
  );
  modport sink (
    input valid, output ready,
    input block_offset, input header_crc, input header_size, input block_type,
    input header_flags, input extra_size, input data_size, input data_offset,
    input is_target, input status, input end_of_stream
  );
endinterface

`default_nettype wire

// File: src/archive_block_header_walker.sv
// Sustains one byte per clock while the descriptor output is not stalled: each accepted
// byte is written into a slot of a two-entry queue and consumed from there by the parser,
// and the descriptor it completes is registered in the output stage. The cycle is set
// by the parser step (varint merge plus the saturating header-end or skip-target add
// and compare). No clearing pass after reset; the block takes bytes at once.
// Depends on hbw_pkg, hbw_in_if, hbw_out_if, hbw_front and hbw_back.
`default_nettype none

module archive_block_header_walker
  import hbw_pkg::*;
#(
  parameter int unsigned OFFSET_BITS      = 48,
  parameter int unsigned VARINT_MAX_BYTES = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  hbw_in_if.sink                     in_ch,
  hbw_out_if.source                  out_ch
);

  hbw_cfg_t  cfg_q;
  hbw_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sig_len <= SIG_LEN_RST;
      cfg_q.target  <= TARGET_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IDX_SIG_LEN) begin
        cfg_q.sig_len <= cfg_data_i;
      end else if (cfg_idx_i == CFG_IDX_TARGET) begin
        cfg_q.target <= cfg_data_i;
      end
    end
  end

  hbw_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  hbw_back #(
    .OFFSET_BITS      (OFFSET_BITS),
    .VARINT_MAX_BYTES (VARINT_MAX_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_stream_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.status == ST_TRUNC || out_ch.status == ST_END)
      |-> out_ch.end_of_stream)
    else $error("truncated or end marker without end_of_stream");

  a_end_marker_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.status == ST_END
      |-> !out_ch.is_target && out_ch.header_size == '0 && out_ch.data_offset == '0)
    else $error("end marker carries header fields");

  a_hdr_end_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && (out_ch.status == ST_COMPLETE || out_ch.status == ST_BACKSKIP)
      |-> out_ch.data_offset >= out_ch.block_offset)
    else $error("header end before block start");

  a_cfg_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == CFG_IDX_TARGET |=> cfg_q.target == $past(cfg_data_i))
    else $error("target type write lost");
`endif

endmodule

`default_nettype wire

// File: src/hbw_front.sv
// Front end: accepts stream bytes, classifies them and holds them in a
// two-entry queue for the parser. Uses hbw_pkg and hbw_in_if.
`default_nettype none

module hbw_front
  import hbw_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hbw_in_if.sink     in_ch,
  output hbw_item_t  q_item_o,
  output logic       q_valid_o,
  input  wire logic  q_pop_i
);

  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  hbw_item_t  slot_q [2];
  hbw_item_t  item;
  logic       push;
  logic       pop;

  always_comb begin
    item.value = in_ch.byte_value;
    item.group = in_ch.byte_value[6:0];
    item.cont  = in_ch.byte_value[7];
    item.last  = in_ch.last;
  end

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign pop         = q_pop_i && q_valid_o;
  assign q_item_o    = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item;
    end
  end

endmodule

`default_nettype wire

// File: src/hbw_back.sv
// Back end: block header phase machine, varint decode, skip tracking and the
// registered descriptor output. Uses hbw_pkg and hbw_out_if.
`default_nettype none

module hbw_back
  import hbw_pkg::*;
#(
  parameter int unsigned OFFSET_BITS      = 48,
  parameter int unsigned VARINT_MAX_BYTES = 10
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hbw_cfg_t   cfg_i,
  input  wire hbw_item_t  q_item_i,
  input  wire logic       q_valid_i,
  output logic            q_pop_o,
  hbw_out_if.source       out_ch
);

  localparam int unsigned OB    = OFFSET_BITS;
  localparam int unsigned CNT_W = $clog2(VARINT_MAX_BYTES + 1);
  localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};

  function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a,
                                            input logic [FIELD_W-1:0] b);
    logic [FIELD_W:0] s;
    begin
      s = (FIELD_W + 1)'(a) + (FIELD_W + 1)'(b);
      sat_add = (|s[FIELD_W:OB]) ? OFF_MAX : s[OB-1:0];
    end
  endfunction

  hbw_phase_e phase_q, phase_d, ph;
  logic [OB-1:0]      pos_q, pos_d, next_pos;
  logic [1:0]         crc_cnt_q, crc_cnt_d;
  logic [CNT_W-1:0]   vcnt_q, vcnt_d, vcnt_inc;
  logic [FIELD_W-1:0] acc_q, acc_d, acc_new, shifted, fin_data;
  logic [CRC_W-1:0]   crc_q, crc_d, crc_base;
  logic [FIELD_W-1:0] hsize_q, hsize_d, btype_q, btype_d, flags_q, flags_d;
  logic [FIELD_W-1:0] extra_q, extra_d, data_q, data_d;
  logic [OB-1:0]      hstart_q, hstart_d, hend_q, hend_d, tgt_q, tgt_d, tgt;
  logic [6:0]         sh;
  logic               fire, is_varint, vdone, finish, emit, type_match;
  hbw_status_e        fin_status;

  logic               out_valid_q, out_valid_d, out_load;
  logic [OB-1:0]      o_boff_q, o_boff_d, o_doff_q, o_doff_d;
  logic [CRC_W-1:0]   o_crc_q, o_crc_d;
  logic [FIELD_W-1:0] o_hsize_q, o_hsize_d, o_type_q, o_type_d, o_flags_q, o_flags_d;
  logic [FIELD_W-1:0] o_extra_q, o_extra_d, o_data_q, o_data_d;
  logic               o_tgt_q, o_tgt_d, o_eos_q, o_eos_d;
  hbw_status_e        o_stat_q, o_stat_d;

  assign fire    = q_valid_i && (!out_valid_q || out_ch.ready);
  assign q_pop_o = fire;

  assign next_pos = (pos_q == OFF_MAX) ? pos_q : pos_q + OB'(1);
  assign ph = (phase_q == PH_SIG && pos_q >= OB'(cfg_i.sig_len)) ? PH_CRC : phase_q;
  assign is_varint = (ph == PH_HSIZE) || (ph == PH_TYPE) || (ph == PH_FLAGS) ||
                     (ph == PH_EXTRA) || (ph == PH_DATA);

  assign sh       = 7'(vcnt_q) * 7'd7;
  assign shifted  = sh[6] ? '0 : (FIELD_W'(q_item_i.group) << sh[5:0]);
  assign acc_new  = acc_q | shifted;
  assign vcnt_inc = vcnt_q + CNT_W'(1);
  assign vdone    = !q_item_i.cont || (vcnt_inc >= CNT_W'(VARINT_MAX_BYTES));
  assign fin_data = (ph == PH_DATA) ? acc_new : data_q;
  assign tgt      = sat_add(hend_q, fin_data);
  assign crc_base = (crc_cnt_q == 2'd0) ? '0 : crc_q;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    crc_cnt_d  = crc_cnt_q;
    vcnt_d     = vcnt_q;
    acc_d      = acc_q;
    crc_d      = crc_q;
    hsize_d    = hsize_q;
    btype_d    = btype_q;
    flags_d    = flags_q;
    extra_d    = extra_q;
    data_d     = data_q;
    hstart_d   = hstart_q;
    hend_d     = hend_q;
    tgt_d      = tgt_q;
    finish     = 1'b0;
    fin_status = ST_COMPLETE;

    if (fire) begin
      pos_d   = next_pos;
      phase_d = ph;
      case (ph)
        PH_CRC: begin
          if (crc_cnt_q == 2'd0) begin
            hstart_d = pos_q;
            hend_d   = '0;
            hsize_d  = '0;
            btype_d  = '0;
            flags_d  = '0;
            extra_d  = '0;
            data_d   = '0;
          end
          crc_d     = crc_base | (CRC_W'(q_item_i.value) << {crc_cnt_q, 3'b000});
          crc_cnt_d = crc_cnt_q + 2'd1;
          if (crc_cnt_q == 2'd3) begin
            phase_d = PH_HSIZE;
            acc_d   = '0;
            vcnt_d  = '0;
          end
        end
        PH_HSIZE: hsize_d = acc_new;
        PH_TYPE:  btype_d = acc_new;
        PH_FLAGS: flags_d = acc_new;
        PH_EXTRA: extra_d = acc_new;
        PH_DATA:  data_d  = acc_new;
        PH_SKIP: begin
          if (next_pos == tgt_q) begin
            phase_d = PH_CRC;
          end
        end
        default: begin
        end
      endcase

      if (is_varint) begin
        acc_d  = acc_new;
        vcnt_d = vcnt_inc;
        if (vdone) begin
          acc_d  = '0;
          vcnt_d = '0;
          case (ph)
            PH_HSIZE: begin
              hend_d  = sat_add(next_pos, acc_new);
              phase_d = PH_TYPE;
            end
            PH_TYPE: phase_d = PH_FLAGS;
            PH_FLAGS: begin
              if (acc_new[0]) begin
                phase_d = PH_EXTRA;
              end else if (acc_new[1]) begin
                phase_d = PH_DATA;
              end else begin
                finish = 1'b1;
              end
            end
            PH_EXTRA: begin
              if (flags_q[1]) begin
                phase_d = PH_DATA;
              end else begin
                finish = 1'b1;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end

      if (finish) begin
        tgt_d   = tgt;
        phase_d = (tgt <= next_pos) ? PH_CRC : PH_SKIP;
        if (tgt < next_pos) begin
          fin_status = ST_BACKSKIP;
        end
      end
    end
  end

  assign emit       = fire && finish;
  assign type_match = (btype_d == FIELD_W'(cfg_i.target));

  // descriptor build; stream reset on the final byte comes after
  always_comb begin
    out_load  = 1'b0;
    o_boff_d  = hstart_d;
    o_crc_d   = crc_d;
    o_hsize_d = hsize_d;
    o_type_d  = btype_d;
    o_flags_d = flags_d;
    o_extra_d = extra_d;
    o_data_d  = data_d;
    o_doff_d  = hend_d;
    o_tgt_d   = type_match;
    o_stat_d  = fin_status;
    o_eos_d   = q_item_i.last;
    if (emit) begin
      out_load = 1'b1;
    end else if (fire && q_item_i.last) begin
      out_load = 1'b1;
      if ((phase_d == PH_HSIZE) || (phase_d == PH_TYPE) || (phase_d == PH_FLAGS) ||
          (phase_d == PH_EXTRA) || (phase_d == PH_DATA)) begin
        o_stat_d = ST_TRUNC;
        o_tgt_d  = type_match && ((phase_d == PH_FLAGS) || (phase_d == PH_EXTRA) ||
                                  (phase_d == PH_DATA));
      end else begin
        o_stat_d  = ST_END;
        o_boff_d  = '0;
        o_crc_d   = '0;
        o_hsize_d = '0;
        o_type_d  = '0;
        o_flags_d = '0;
        o_extra_d = '0;
        o_data_d  = '0;
        o_doff_d  = '0;
        o_tgt_d   = 1'b0;
      end
    end
    out_valid_d = out_load || (out_valid_q && !out_ch.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIG;
      pos_q       <= '0;
      crc_cnt_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire && q_item_i.last) begin
        phase_q   <= PH_SIG;
        pos_q     <= '0;
        crc_cnt_q <= 2'd0;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        crc_cnt_q <= crc_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vcnt_q   <= vcnt_d;
    acc_q    <= acc_d;
    crc_q    <= crc_d;
    hsize_q  <= hsize_d;
    btype_q  <= btype_d;
    flags_q  <= flags_d;
    extra_q  <= extra_d;
    data_q   <= data_d;
    hstart_q <= hstart_d;
    hend_q   <= hend_d;
    tgt_q    <= tgt_d;
    if (out_load) begin
      o_boff_q  <= o_boff_d;
      o_crc_q   <= o_crc_d;
      o_hsize_q <= o_hsize_d;
      o_type_q  <= o_type_d;
      o_flags_q <= o_flags_d;
      o_extra_q <= o_extra_d;
      o_data_q  <= o_data_d;
      o_doff_q  <= o_doff_d;
      o_tgt_q   <= o_tgt_d;
      o_stat_q  <= o_stat_d;
      o_eos_q   <= o_eos_d;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.block_offset  = o_boff_q;
  assign out_ch.header_crc    = o_crc_q;
  assign out_ch.header_size   = o_hsize_q;
  assign out_ch.block_type    = o_type_q;
  assign out_ch.header_flags  = o_flags_q;
  assign out_ch.extra_size    = o_extra_q;
  assign out_ch.data_size     = o_data_q;
  assign out_ch.data_offset   = o_doff_q;
  assign out_ch.is_target     = o_tgt_q;
  assign out_ch.status        = o_stat_q;
  assign out_ch.end_of_stream = o_eos_q;

endmodule

`default_nettype wire

// File: verif/hbw_header_monitor.sv
`timescale 1ns / 1ps
// Descriptor monitor for the archive block header walker: tracks register writes,
// predicts descriptors from accepted bytes and compares them with the output.
// Depends on hbw_pkg, hbw_in_if and hbw_out_if.

module hbw_header_monitor
  import hbw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hbw_in_if                     in_mon,
  hbw_out_if                    out_mon,
  output int                    fail_count_o,
  output int                    pending_count_o
);

  localparam logic [63:0] OFFSET_MAX   = 64'h0000_FFFF_FFFF_FFFF;
  localparam int unsigned VARINT_LIMIT = 10;

  typedef struct packed {
    logic [47:0] block_offset;
    logic [31:0] header_crc;
    logic [63:0] header_size;
    logic [63:0] block_type;
    logic [63:0] header_flags;
    logic [63:0] extra_size;
    logic [63:0] data_size;
    logic [47:0] data_offset;
    logic        is_target;
    hbw_status_e status;
    logic        end_of_stream;
  } hbw_desc_t;

  hbw_desc_t   expected_desc_q[$];
  logic [7:0]  sig_len;
  logic [7:0]  target;
  logic [47:0] byte_pos;
  logic [47:0] hdr_start;
  logic [47:0] hdr_end;
  hbw_phase_e  phase;
  logic [63:0] acc;
  logic [3:0]  groups;
  logic [1:0]  crc_cnt;
  logic [63:0] fields [6];
  logic [63:0] skip_left;

  function automatic logic [63:0] sat_offset(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64] || s[63:0] > OFFSET_MAX) return OFFSET_MAX;
    return s[63:0];
  endfunction

  function automatic string desc_str(input hbw_desc_t d);
    return $sformatf({"off=%h crc=%h hsz=%h typ=%h flg=%h ext=%h dsz=%h doff=%h",
                      " tgt=%b st=%0d eos=%b"},
                     d.block_offset, d.header_crc, d.header_size, d.block_type,
                     d.header_flags, d.extra_size, d.data_size, d.data_offset,
                     d.is_target, d.status, d.end_of_stream);
  endfunction

  function automatic hbw_desc_t header_desc(input hbw_status_e st, input logic type_done,
                                            input logic eos);
    hbw_desc_t d;
    d.block_offset  = hdr_start;
    d.header_crc    = fields[0][31:0];
    d.header_size   = fields[1];
    d.block_type    = fields[2];
    d.header_flags  = fields[3];
    d.extra_size    = fields[4];
    d.data_size     = fields[5];
    d.data_offset   = hdr_end;
    d.is_target     = type_done && (fields[2] == {56'd0, target});
    d.status        = st;
    d.end_of_stream = eos;
    return d;
  endfunction

  task automatic restart_stream();
    byte_pos  = '0;
    phase     = PH_SIG;
    acc       = '0;
    groups    = '0;
    crc_cnt   = '0;
    foreach (fields[i]) fields[i] = '0;
    hdr_start = '0;
    hdr_end   = '0;
    skip_left = '0;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic is_last);
    logic [63:0] nxt;
    logic [63:0] tgt;
    int unsigned sh;
    int          fi;
    logic        emit;
    logic        fin;
    hbw_status_e st;
    hbw_desc_t   d;
    nxt  = sat_offset({16'd0, byte_pos}, 64'd1);
    emit = 1'b0;
    fin  = 1'b0;
    st   = ST_COMPLETE;
    if (phase == PH_SIG && byte_pos >= 48'(sig_len)) phase = PH_CRC;
    case (phase)
      PH_CRC: begin
        if (crc_cnt == 2'd0) begin
          hdr_start = byte_pos;
          hdr_end   = '0;
          foreach (fields[i]) fields[i] = '0;
        end
        fields[0] |= 64'(b) << (8 * crc_cnt);
        crc_cnt = crc_cnt + 2'd1;
        if (crc_cnt == 2'd0) begin
          phase  = PH_HSIZE;
          acc    = '0;
          groups = '0;
        end
      end
      PH_HSIZE, PH_TYPE, PH_FLAGS, PH_EXTRA, PH_DATA: begin
        case (phase)
          PH_HSIZE: fi = 1;
          PH_TYPE:  fi = 2;
          PH_FLAGS: fi = 3;
          PH_EXTRA: fi = 4;
          default:  fi = 5;
        endcase
        sh = 7 * groups;
        if (sh < 64) acc |= 64'(b[6:0]) << sh;
        groups = groups + 4'd1;
        fields[fi] = acc;
        if (!b[7] || groups >= VARINT_LIMIT) begin
          acc    = '0;
          groups = '0;
          case (phase)
            PH_HSIZE: begin
              hdr_end = 48'(sat_offset(nxt, fields[1]));
              phase   = PH_TYPE;
            end
            PH_TYPE: phase = PH_FLAGS;
            PH_FLAGS: begin
              if (fields[3][0]) phase = PH_EXTRA;
              else if (fields[3][1]) phase = PH_DATA;
              else fin = 1'b1;
            end
            PH_EXTRA: begin
              if (fields[3][1]) phase = PH_DATA;
              else fin = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
        if (fin) begin
          tgt = sat_offset({16'd0, hdr_end}, fields[5]);
          if (tgt < nxt) begin
            skip_left = '0;
            st        = ST_BACKSKIP;
          end else begin
            skip_left = tgt - nxt;
          end
          phase = (skip_left != 0) ? PH_SKIP : PH_CRC;
          emit  = 1'b1;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 64'd1;
        if (skip_left == 0) phase = PH_CRC;
      end
      default: ;
    endcase
    byte_pos = nxt[47:0];

    if (emit) begin
      expected_desc_q.push_back(header_desc(st, 1'b1, is_last));
    end else if (is_last) begin
      if (phase inside {PH_HSIZE, PH_TYPE, PH_FLAGS, PH_EXTRA, PH_DATA}) begin
        expected_desc_q.push_back(header_desc(ST_TRUNC,
                                  phase inside {PH_FLAGS, PH_EXTRA, PH_DATA}, 1'b1));
      end else begin
        d               = '0;
        d.status        = ST_END;
        d.end_of_stream = 1'b1;
        expected_desc_q.push_back(d);
      end
    end
    if (is_last) restart_stream();
  endtask

  always @(posedge clk_i) begin
    hbw_desc_t got;
    hbw_desc_t want;
    if (!rst_ni) begin
      sig_len = SIG_LEN_RST;
      target  = TARGET_RST;
      restart_stream();
      expected_desc_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.block_offset  = out_mon.block_offset;
        got.header_crc    = out_mon.header_crc;
        got.header_size   = out_mon.header_size;
        got.block_type    = out_mon.block_type;
        got.header_flags  = out_mon.header_flags;
        got.extra_size    = out_mon.extra_size;
        got.data_size     = out_mon.data_size;
        got.data_offset   = out_mon.data_offset;
        got.is_target     = out_mon.is_target;
        got.status        = hbw_status_e'(out_mon.status);
        got.end_of_stream = out_mon.end_of_stream;
        if (expected_desc_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] unexpected descriptor: %s", $time, desc_str(got));
        end else begin
          want = expected_desc_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("[%0t] descriptor mismatch\n  exp: %s\n  got: %s", $time,
                       desc_str(want), desc_str(got));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_SIG_LEN: sig_len = cfg_data_i;
          CFG_IDX_TARGET:  target  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) walk_byte(in_mon.byte_value, in_mon.last);
    end
    pending_count_o = expected_desc_q.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Top of the header walker testbench: clock, reset, byte streams built from
// random block headers, register phases and the verdict.
// Depends on hbw_pkg, hbw_in_if, hbw_out_if, hbw_header_monitor and the walker.

module tb;
  import hbw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd2;
  localparam int RANDOM_ITEMS  = 850;
  localparam int PHASE_ITEMS   = 110;
  localparam int SETTLE_CYCLES = 6;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_count;

  logic [7:0] stream_bytes[$];
  logic [7:0] sig_len;
  logic [7:0] target;
  int         item_count;
  bit         src_steady;

  hbw_in_if                       in_ch ();
  hbw_out_if #(.OFFSET_BITS(48))  out_ch ();

  archive_block_header_walker #(
    .OFFSET_BITS      (48),
    .VARINT_MAX_BYTES (10)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  hbw_header_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  // descriptor sink: random stalls, with stretches of steady ready
  initial begin : sink_side
    int gap;
    bit steady;
    steady       = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.byte_value <= b;
    in_ch.last       <= is_last;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_stream(input int cut);
    for (int i = 0; i < cut; i++) begin
      send_byte(stream_bytes[i], i == cut - 1);
      item_count++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for every expected descriptor, then let the pipeline drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int varint_pad();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  task automatic push_varint(input logic [63:0] v, input int pad);
    logic [6:0] grp [10];
    int         n;
    int         total;
    n = 0;
    do begin
      grp[n] = v[6:0];
      v = v >> 7;
      n++;
    end while (v != 0 && n < 10);
    total = (n + pad > 10) ? 10 : n + pad;
    for (int i = 0; i < total; i++)
      stream_bytes.push_back({i < total - 1, (i < n) ? grp[i] : 7'd0});
  endtask

  // raw varint bytes; a ten byte one may keep its continuation bit
  task automatic push_noise_varint(output logic [7:0] first);
    int         n;
    logic [7:0] b;
    n = ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(2, 10);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i < n - 1) b[7] = 1'b1;
      else if (n != 10) b[7] = 1'b0;
      if (i == 0) first = b;
      stream_bytes.push_back(b);
    end
  endtask

  task automatic add_block(input bit final_blk);
    logic [7:0]      b;
    logic [7:0]      fl;
    logic [63:0]     hsize;
    logic [63:0]     dsize;
    longint unsigned hend;
    int              crc_kind;
    bit              huge;
    crc_kind = $urandom_range(0, 5);
    repeat (4) begin
      b = (crc_kind == 0) ? 8'h00 : (crc_kind == 1) ? 8'hFF : 8'($urandom);
      stream_bytes.push_back(b);
    end
    // huge sizes saturate the offsets and skip past the stream end
    huge = final_blk && ($urandom_range(0, 7) == 0);
    if (huge)
      hsize = ($urandom_range(0, 3) == 0) ? '1 :
              {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
    else
      hsize = 64'($urandom_range(0, 24));
    push_varint(hsize, varint_pad());
    hend = stream_bytes.size() + hsize;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_varint({56'd0, target}, varint_pad());
      4, 5, 6:    push_varint(64'($urandom_range(0, 7)), varint_pad());
      7:          push_varint({$urandom, $urandom}, 0);
      default:    push_noise_varint(b);
    endcase
    push_noise_varint(fl);
    if (fl[0]) begin
      if ($urandom_range(0, 1) == 0) push_noise_varint(b);
      else push_varint({$urandom, $urandom}, varint_pad());
    end
    dsize = '0;
    if (fl[1]) begin
      dsize = huge ? {$urandom, $urandom} : 64'($urandom_range(0, 30));
      push_varint(dsize, varint_pad());
    end
    if (huge) begin
      repeat ($urandom_range(0, 6)) stream_bytes.push_back(8'($urandom));
    end else begin
      while (stream_bytes.size() < hend + dsize) stream_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic random_stream();
    int nblk;
    int cut;
    stream_bytes.delete();
    repeat (sig_len) stream_bytes.push_back(8'($urandom));
    nblk = $urandom_range(1, 4);
    for (int i = 0; i < nblk; i++) add_block(i == nblk - 1);
    cut = ($urandom_range(0, 99) < 45) ? $urandom_range(1, stream_bytes.size())
                                       : stream_bytes.size();
    src_steady = ($urandom_range(0, 3) == 0);
    send_stream(cut);
  endtask

  initial begin
    int phase_idx;
    int phase_end;
    int phase_streams;
    in_ch.valid      = 1'b0;
    in_ch.byte_value = '0;
    in_ch.last       = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    rst_ni           = 1'b0;
    sig_len          = SIG_LEN_RST;
    target           = TARGET_RST;
    src_steady       = 1'b0;
    item_count       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // stream ending inside the signature
    stream_bytes = '{8'h5A};
    send_stream(1);
    settle();
    write_reg(CFG_IDX_SIG_LEN, 8'd0);
    sig_len = 8'd0;
    write_reg(CFG_IDX_UNUSED, 8'hFF);
    // header done on the last byte, backward skip, target match
    stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h03, 8'h00};
    send_stream(7);
    // end on the last crc byte, truncated in the header size
    stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_stream(4);
    // truncated in the extra size
    stream_bytes = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h02, 8'h7F, 8'h03, 8'h80};
    send_stream(8);
    // truncated in the header size
    stream_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h85};
    send_stream(5);

    item_count = 0;
    phase_idx  = 0;
    while (item_count < RANDOM_ITEMS) begin
      settle();
      case (phase_idx)
        0: begin
          sig_len = 8'd0;
          target  = 8'd255;
        end
        1: begin
          sig_len = 8'd255;
          target  = 8'd0;
        end
        2: begin
          sig_len = 8'd1;
          target  = TARGET_RST;
        end
        3: begin
          sig_len = SIG_LEN_RST;
          target  = 8'($urandom);
        end
        default: begin
          sig_len = 8'($urandom_range(0, 12));
          target  = 8'($urandom);
        end
      endcase
      write_reg(CFG_IDX_SIG_LEN, sig_len);
      write_reg(CFG_IDX_TARGET, target);
      phase_end     = item_count + PHASE_ITEMS;
      phase_streams = 0;
      while (item_count < phase_end && item_count < RANDOM_ITEMS &&
             !(sig_len > 8'd32 && phase_streams == 2)) begin
        random_stream();
        phase_streams++;
      end
      phase_idx++;
    end

    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
